// ===== design/ialu_pkg.sv =====
// Shared types, codes and sizes for the integer ALU with Fibonacci unit.
`timescale 1ns / 1ps
package ialu_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FIB_MAX_INDEX = 46;

  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int KIND_W = 3;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_FIB = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV0   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADOP  = 2'd2;
  localparam logic [ST_W-1:0] ST_FIBBIG = 2'd3;

  // Work kinds handed to the execution side
  localparam logic [KIND_W-1:0] K_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] K_SUB   = 3'd1;
  localparam logic [KIND_W-1:0] K_MUL   = 3'd2;
  localparam logic [KIND_W-1:0] K_DIV   = 3'd3;
  localparam logic [KIND_W-1:0] K_FIB   = 3'd4;
  localparam logic [KIND_W-1:0] K_CONST = 3'd5;

  localparam int FIB_CNT_W = $clog2(FIB_MAX_INDEX + 1);
  localparam int DIV_CNT_W = $clog2(DATA_WIDTH);
  localparam int CNT_W     = (FIB_CNT_W > DIV_CNT_W) ? FIB_CNT_W : DIV_CNT_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ST_W-1:0]   status;
    word_t             a;
    word_t             b;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

endpackage

// ===== design/ialu_front.sv =====
// Request decode: classifies each item and resolves the error cases up front.
`timescale 1ns / 1ps
module ialu_front import ialu_pkg::*; (
  input  logic [OP_W-1:0] in_req_type,
  input  word_t           in_operand_a,
  input  word_t           in_operand_b,
  output cmd_t            cmd
);

  logic a_neg;
  logic a_zero;
  logic a_big;

  assign a_neg  = in_operand_a[DATA_WIDTH-1];
  assign a_zero = (in_operand_a == '0);
  assign a_big  = (in_operand_a > word_t'(FIB_MAX_INDEX));

  always_comb begin
    cmd.a      = in_operand_a;
    cmd.b      = in_operand_b;
    cmd.status = ST_OK;
    cmd.kind   = K_CONST;
    // F(1) needs no step, so the loop count is index minus one
    cmd.cnt    = in_operand_a[CNT_W-1:0] - CNT_W'(1);
    unique case (in_req_type)
      OP_ADD: cmd.kind = K_ADD;
      OP_SUB: cmd.kind = K_SUB;
      OP_MUL: cmd.kind = K_MUL;
      OP_DIV: begin
        if (in_operand_b == '0) begin
          cmd.status = ST_DIV0;
        end else begin
          cmd.kind = K_DIV;
        end
      end
      OP_FIB: begin
        if (a_neg || a_zero) begin
          cmd.status = ST_OK;
        end else if (a_big) begin
          cmd.status = ST_FIBBIG;
        end else begin
          cmd.kind = K_FIB;
        end
      end
      default: cmd.status = ST_BADOP;
    endcase
  end

endmodule

// ===== design/ialu_queue.sv =====
// Short command queue between decode and execution.
`timescale 1ns / 1ps
module ialu_queue import ialu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== design/ialu_back.sv =====
// Execution side: add, subtract, multiply, iterative divide and Fibonacci.
`timescale 1ns / 1ps
module ialu_back import ialu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      out_empty,
  input  logic      out_pop,
  output word_t     out_result,
  output logic [ST_W-1:0] out_status
);

  localparam int SW = 3;
  localparam logic [SW-1:0] S_IDLE = 3'd0;
  localparam logic [SW-1:0] S_MUL  = 3'd1;
  localparam logic [SW-1:0] S_DIV  = 3'd2;
  localparam logic [SW-1:0] S_DSGN = 3'd3;
  localparam logic [SW-1:0] S_FIB  = 3'd4;
  localparam logic [SW-1:0] S_DONE = 3'd5;

  logic [SW-1:0]     state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             x_r, x_nxt;     // quotient / current term
  word_t             y_r, y_nxt;     // remainder / previous term
  word_t             dvs_r, dvs_nxt; // divisor magnitude / multiplicand
  logic              neg_r, neg_nxt;
  word_t             res_r, res_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  word_t             out_result_r, out_result_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;

  logic [DATA_WIDTH:0]     rem_sh;
  logic [DATA_WIDTH:0]     rem_diff;
  logic                    ge;
  logic [2*DATA_WIDTH-1:0] prod;
  word_t                   mag_a;
  word_t                   mag_b;

  assign rem_sh   = {y_r, x_r[DATA_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = !rem_diff[DATA_WIDTH];
  assign prod     = x_r * dvs_r;
  assign mag_a    = cmd.a[DATA_WIDTH-1] ? (~cmd.a + word_t'(1)) : cmd.a;
  assign mag_b    = cmd.b[DATA_WIDTH-1] ? (~cmd.b + word_t'(1)) : cmd.b;

  assign cmd_take   = (state_r == S_IDLE) && cmd_valid;
  assign out_empty  = !out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    x_nxt          = x_r;
    y_nxt          = y_r;
    dvs_nxt        = dvs_r;
    neg_nxt        = neg_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          st_nxt    = cmd.status;
          state_nxt = S_DONE;
          unique case (cmd.kind)
            K_ADD: res_nxt = cmd.a + cmd.b;
            K_SUB: res_nxt = cmd.a - cmd.b;
            K_MUL: begin
              x_nxt     = cmd.a;
              dvs_nxt   = cmd.b;
              state_nxt = S_MUL;
            end
            K_DIV: begin
              x_nxt     = mag_a;
              y_nxt     = '0;
              dvs_nxt   = mag_b;
              neg_nxt   = cmd.a[DATA_WIDTH-1] ^ cmd.b[DATA_WIDTH-1];
              cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
              state_nxt = S_DIV;
            end
            K_FIB: begin
              x_nxt     = word_t'(1);
              y_nxt     = '0;
              cnt_nxt   = cmd.cnt;
              state_nxt = S_FIB;
            end
            default: res_nxt = (cmd.status == ST_OK) ? '0 : '1;
          endcase
        end
      end
      S_MUL: begin
        res_nxt   = prod[DATA_WIDTH-1:0];
        state_nxt = S_DONE;
      end
      S_DIV: begin
        y_nxt = ge ? rem_diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        x_nxt = {x_r[DATA_WIDTH-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = S_DSGN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DSGN: begin
        res_nxt   = neg_r ? (~x_r + word_t'(1)) : x_r;
        state_nxt = S_DONE;
      end
      S_FIB: begin
        if (cnt_r == '0) begin
          res_nxt   = x_r;
          state_nxt = S_DONE;
        end else begin
          x_nxt   = x_r + y_r;
          y_nxt   = x_r;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_pop) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_r;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    dvs_r        <= dvs_nxt;
    neg_r        <= neg_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

  a_err_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_result_r == '1))
    else $error("error status without all-ones result");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != '0))
    else $error("divide running with zero divisor");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> (state_r != S_IDLE))
    else $error("command taken but execution did not start");

endmodule

// ===== design/integer_alu_with_fibonacci_unit.sv =====
// Top level of the integer ALU with Fibonacci unit.
`timescale 1ns / 1ps
// Usage:
//   Input side is a queue: drive in_req_type / in_operand_a / in_operand_b and
//   raise in_push; the item is taken at a clock edge where full is low.
//   Result side is a queue too: while out_empty is low, out_result and
//   out_status show the oldest result; raise out_pop to take it.
//   Every item yields exactly one result, in order.
// Path from accept to out_empty low, output idle: the queue entry, then
//   the execution states, then S_DONE loads the output register. Add,
//   subtract and errors go straight to S_DONE; multiply passes S_MUL;
//   divide runs S_DIV (one quotient bit per cycle, radix-2), then S_DSGN;
//   Fibonacci of index n runs S_FIB (one term per cycle).
// The execution unit takes one item at a time, so divide and Fibonacci
//   loops hold the items behind them until their result leaves S_DONE.
// A two-entry command queue separates decode from execution, so pushes
//   continue while a long operation runs or a result waits.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// A stalled receiver holds the result; the finished next result waits in
//   the execution unit, and the queue fills until full rises.
module integer_alu_with_fibonacci_unit import ialu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [OP_W-1:0]       in_req_type,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [DATA_WIDTH-1:0] out_result,
  output logic [ST_W-1:0]       out_status
);

  cmd_t  dec_cmd;
  cmd_t  head_cmd;
  logic  head_valid;
  logic  cmd_take;
  word_t res_w;

  // Decode: error cases and the trivial Fibonacci cases are settled here
  ialu_front u_front (
    .in_req_type  (in_req_type),
    .in_operand_a (word_t'(in_operand_a)),
    .in_operand_b (word_t'(in_operand_b)),
    .cmd          (dec_cmd)
  );

  // Decoded commands wait here while the execution unit is busy
  ialu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .push_cmd   (dec_cmd),
    .full       (in_full),
    .pop        (cmd_take),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Execution with its own output register
  ialu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_take   (cmd_take),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (res_w),
    .out_status (out_status)
  );

  assign out_result = $signed(res_w);

endmodule
